### design/tap_pkg.sv
// Shared types and constants for the tile average pixelate block.
`timescale 1ns / 1ps

package tap_pkg;

  // Pixel channel width and configuration register width
  localparam int PIX_W  = 8;
  localparam int CFG_W  = 7;

  // Tile edge after reset
  localparam int TILE_SIZE_RESET = 15;

  // Quotient bits produced by the divider, one per cycle
  localparam int DIV_STEPS = PIX_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;      // add the item to the running sums
    logic tile_close;  // load the divider, clear the sums
    logic div_step;    // produce one quotient bit
    logic out_load;    // move the quotients to the output register
  } tap_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic will_complete;  // the next item closes the tile
  } tap_status_t;

endpackage

### design/tap_ctrl.sv
// Controller: handshakes, tile close sequencing and divider step count.
`timescale 1ns / 1ps

module tap_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  output logic                mean_valid,
  input  logic                mean_stall,
  input  tap_pkg::tap_status_t status,
  output tap_pkg::tap_cmd_t   cmd
);
  import tap_pkg::*;

  typedef enum logic [2:0] {
    ST_ACCUM = 3'b001,
    ST_DIV   = 3'b010,
    ST_WAIT  = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic              accept;
  logic              out_free;
  logic              last_step;

  // Stall only an item that would close a tile while a result is still in the divider
  assign pixel_stall = (state != ST_ACCUM) && status.will_complete;
  assign accept      = pixel_valid && !pixel_stall;
  assign out_free    = !mean_valid || !mean_stall;
  assign last_step   = (step == STEP_W'(DIV_STEPS - 1));

  // Decode commands
  always_comb begin
    cmd.accept     = accept;
    cmd.tile_close = accept && status.will_complete;
    cmd.div_step   = (state == ST_DIV);
    cmd.out_load   = (state == ST_WAIT) && out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCUM: begin
        if (cmd.tile_close) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (last_step) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_free) state_next = ST_ACCUM;
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  // Advance state, step count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_ACCUM;
      step       <= '0;
      mean_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) step <= step + 1'b1;
      else                 step <= '0;
      if (cmd.out_load)     mean_valid <= 1'b1;
      else if (!mean_stall) mean_valid <= 1'b0;
    end
  end

  // Checks
  a_close_only_accum: assert property (@(posedge clk) disable iff (rst)
    cmd.tile_close |-> state == ST_ACCUM)
    else $error("tile closed while divider busy");

  a_close_starts_div: assert property (@(posedge clk) disable iff (rst)
    cmd.tile_close |=> (state == ST_DIV) && (step == '0))
    else $error("divide did not start after tile close");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DIV) && last_step) |=> state == ST_WAIT)
    else $error("divide did not end after last step");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> mean_valid)
    else $error("loaded result not presented");

endmodule

### design/tap_datapath.sv
// Datapath: tile target, running sums, pixel count, per channel divider with shared divisor, output register.
`timescale 1ns / 1ps

module tap_datapath #(
  parameter int MAX_TILE_SIZE = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic [tap_pkg::CFG_W-1:0] tile_size,
  input  logic [tap_pkg::PIX_W-1:0] blue_in,
  input  logic [tap_pkg::PIX_W-1:0] green_in,
  input  logic [tap_pkg::PIX_W-1:0] red_in,
  output logic [tap_pkg::PIX_W-1:0] blue_mean,
  output logic [tap_pkg::PIX_W-1:0] green_mean,
  output logic [tap_pkg::PIX_W-1:0] red_mean,
  input  tap_pkg::tap_cmd_t         cmd,
  output tap_pkg::tap_status_t      status
);
  import tap_pkg::*;

  localparam int EW = $clog2(MAX_TILE_SIZE + 1);
  localparam int CW = $clog2(MAX_TILE_SIZE * MAX_TILE_SIZE + 1);
  localparam int SW = $clog2(255 * MAX_TILE_SIZE * MAX_TILE_SIZE + 1);
  localparam int DW = CW + PIX_W;
  localparam int RST_EDGE = (TILE_SIZE_RESET > MAX_TILE_SIZE) ? MAX_TILE_SIZE
                                                              : TILE_SIZE_RESET;
  localparam logic [CW-1:0] RST_TARGET = CW'(RST_EDGE * RST_EDGE);

  logic [CW-1:0]    target;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_inc;
  logic [8:0]       ts_wide;
  logic [8:0]       ts_clip;
  logic [EW-1:0]    edge_len;
  logic [CW-1:0]    target_next;
  logic [PIX_W-1:0] pix     [3];
  logic [SW-1:0]    sum     [3];
  logic [SW-1:0]    sum_inc [3];
  logic [DW-1:0]    rem     [3];
  logic [PIX_W-1:0] quo     [3];
  logic [DW-1:0]    dsh;

  // Clip the written edge to 1..MAX_TILE_SIZE and square it
  always_comb begin
    ts_wide = {2'b00, tile_size};
    ts_clip = ts_wide;
    if (ts_wide == 9'd0)                ts_clip = 9'd1;
    if (ts_wide > 9'(MAX_TILE_SIZE))    ts_clip = 9'(MAX_TILE_SIZE);
    edge_len    = EW'(ts_clip);
    target_next = CW'(edge_len) * CW'(edge_len);
  end

  always_ff @(posedge clk) begin
    if (rst)            target <= RST_TARGET;
    else if (cfg_valid) target <= target_next;
  end

  assign count_inc            = count + 1'b1;
  assign status.will_complete = (count_inc >= target);

  assign pix[0] = blue_in;
  assign pix[1] = green_in;
  assign pix[2] = red_in;

  // Accumulate the count, clear it when the tile closes
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.tile_close) begin
      count <= '0;
    end else if (cmd.accept) begin
      count <= count_inc;
    end
  end

  // Shifted divisor: closing pixel count << 7, then one place right per step
  always_ff @(posedge clk) begin
    if (cmd.tile_close) dsh <= DW'({count_inc, {(PIX_W - 1){1'b0}}});
    else if (cmd.div_step) dsh <= dsh >> 1;
  end

  // Per channel: running sum and restoring divider
  for (genvar c = 0; c < 3; c++) begin : g_lane
    assign sum_inc[c] = sum[c] + SW'(pix[c]);

    always_ff @(posedge clk) begin
      if (rst) begin
        sum[c] <= '0;
      end else if (cmd.tile_close) begin
        sum[c] <= '0;
      end else if (cmd.accept) begin
        sum[c] <= sum_inc[c];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.tile_close) begin
        rem[c] <= DW'(sum_inc[c]);
        quo[c] <= '0;
      end else if (cmd.div_step) begin
        if (rem[c] >= dsh) begin
          rem[c] <= rem[c] - dsh;
          quo[c] <= {quo[c][PIX_W-2:0], 1'b1};
        end else begin
          quo[c] <= {quo[c][PIX_W-2:0], 1'b0};
        end
      end
    end
  end

  // Hold the means until the next result
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      blue_mean  <= quo[0];
      green_mean <= quo[1];
      red_mean   <= quo[2];
    end
  end

endmodule

### design/tile_average_pixelate.sv
// Top level of the tile average pixelate block: controller plus datapath.
//
//   channel  direction  handshake                 payload
//   pixel    in         pixel_valid/pixel_stall   blue_in, green_in, red_in
//   mean     out        mean_valid/mean_stall     blue_mean, green_mean, red_mean
//   cfg      in         cfg_valid/cfg_ready       tile_size
//
// One pixel is taken per clock while a tile accumulates. The pixel that closes
// a tile starts a restoring divide (one quotient bit per cycle, all three
// channels at once); the mean then moves to the output register. Only a pixel
// that would close the next tile is stalled while a result is still in the
// divider. A stalled mean holds and the divider waits on it. Reset clears the
// sums and count and sets the tile edge to 15.
`timescale 1ns / 1ps

module tile_average_pixelate #(
  parameter int MAX_TILE_SIZE = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pixel_valid,
  output logic                      pixel_stall,
  input  logic [tap_pkg::PIX_W-1:0] blue_in,
  input  logic [tap_pkg::PIX_W-1:0] green_in,
  input  logic [tap_pkg::PIX_W-1:0] red_in,
  output logic                      mean_valid,
  input  logic                      mean_stall,
  output logic [tap_pkg::PIX_W-1:0] blue_mean,
  output logic [tap_pkg::PIX_W-1:0] green_mean,
  output logic [tap_pkg::PIX_W-1:0] red_mean,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tap_pkg::CFG_W-1:0] tile_size
);
  import tap_pkg::*;

  tap_cmd_t    cmd;
  tap_status_t status;

  // Take configuration at any time
  assign cfg_ready = 1'b1;

  tap_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .mean_valid  (mean_valid),
    .mean_stall  (mean_stall),
    .status      (status),
    .cmd         (cmd)
  );

  tap_datapath #(
    .MAX_TILE_SIZE (MAX_TILE_SIZE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .tile_size  (tile_size),
    .blue_in    (blue_in),
    .green_in   (green_in),
    .red_in     (red_in),
    .blue_mean  (blue_mean),
    .green_mean (green_mean),
    .red_mean   (red_mean),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
